// ----- hw/rtl/status_led_pattern_generator_top_macros.svh -----
// Assertion macros shared by the pattern generator modules.
`ifndef STATUS_LED_PATTERN_GENERATOR_TOP_MACROS_SVH
`define STATUS_LED_PATTERN_GENERATOR_TOP_MACROS_SVH

// Check a consequence in the same cycle.
`define SLPG_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the next cycle.
`define SLPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/slpg_pkg.sv -----
package slpg_pkg;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_MODE = 1'b1;

  localparam logic [3:0] MODE_OFF     = 4'd0;
  localparam logic [3:0] MODE_BOOT    = 4'd1;
  localparam logic [3:0] MODE_CONFIG  = 4'd2;
  localparam logic [3:0] MODE_IDLE    = 4'd3;
  localparam logic [3:0] MODE_CAPTURE = 4'd4;
  localparam logic [3:0] MODE_SEND    = 4'd5;
  localparam logic [3:0] MODE_ERROR   = 4'd6;
  localparam logic [3:0] MODE_NOPEER  = 4'd7;
  localparam logic [3:0] MODE_RESET   = 4'd8;

  localparam logic [7:0] PEAK_LEVEL_RESET = 8'd40;

  // Breathe and blink periods in ticks.
  localparam int LONG_PERIOD   = 50;
  localparam int CONFIG_PERIOD = 150;
  localparam int SEND_PERIOD   = 20;
  localparam int FLASH_TICKS   = 5;
  localparam int RESET_BLINK_BIT = 2;

  // floor(x / half) == (x * RECIP) >> RECIP_SHIFT for every x up to half * 255.
  localparam int RECIP_SHIFT = 21;
  localparam logic [17:0] RECIP_LONG   = 18'd83887;
  localparam logic [17:0] RECIP_CONFIG = 18'd27963;
  localparam logic [17:0] RECIP_SEND   = 18'd209716;

  typedef struct packed {
    logic       valid;
    logic [3:0] mode;
    logic [6:0] num;
    logic       lt5;
    logic       on;
  } stage_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

// ----- hw/rtl/slpg_cmd_if.sv -----
interface slpg_cmd_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [3:0] mode_value;

  modport source(output valid, func, mode_value, input ready);
  modport sink(input valid, func, mode_value, output ready);
endinterface

// ----- hw/rtl/slpg_rgb_if.sv -----
interface slpg_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source(output valid, red, green, blue, input ready);
  modport sink(input valid, red, green, blue, output ready);
endinterface

// ----- hw/rtl/slpg_cfg_if.sv -----
interface slpg_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ----- hw/rtl/slpg_phase.sv -----
`include "status_led_pattern_generator_top_macros.svh"

module slpg_phase (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  slpg_cmd_if.sink         cmd,
  output slpg_pkg::stage_t s1
);

  logic [3:0]       mode;
  logic [3:0]       mode_next;
  logic [15:0]      tick_count;
  logic [15:0]      tick_count_next;
  logic [5:0]       r50;
  logic [5:0]       r50_next;
  logic [7:0]       r150;
  logic [7:0]       r150_next;
  logic [4:0]       r20;
  logic [4:0]       r20_next;
  logic             accept;
  logic             mode_change;
  logic             phase_clear;
  logic             phase_ok;
  slpg_pkg::stage_t s1_next;

  assign cmd.ready = adv;
  assign accept    = cmd.valid && adv;

  assign mode_change = accept && (cmd.func == slpg_pkg::FUNC_MODE) && (cmd.mode_value != mode);
  assign phase_clear = (tick_count == '0) && (r50 == '0) && (r150 == '0) && (r20 == '0);
  assign phase_ok    = (r50 < 6'(slpg_pkg::LONG_PERIOD)) &&
                       (r150 < 8'(slpg_pkg::CONFIG_PERIOD)) &&
                       (r20 < 5'(slpg_pkg::SEND_PERIOD));

  always_comb begin
    mode_next       = mode;
    tick_count_next = tick_count;
    r50_next        = r50;
    r150_next       = r150;
    r20_next        = r20;
    if (accept) begin
      if (cmd.func == slpg_pkg::FUNC_MODE) begin
        if (cmd.mode_value != mode) begin
          mode_next       = cmd.mode_value;
          tick_count_next = '0;
          r50_next        = '0;
          r150_next       = '0;
          r20_next        = '0;
        end
      end else if (tick_count == 16'hFFFF) begin
        // wrap restarts every phase
        tick_count_next = '0;
        r50_next        = '0;
        r150_next       = '0;
        r20_next        = '0;
      end else begin
        tick_count_next = tick_count + 16'd1;
        r50_next  = (r50 == 6'(slpg_pkg::LONG_PERIOD - 1)) ? 6'd0 : r50 + 6'd1;
        r150_next = (r150 == 8'(slpg_pkg::CONFIG_PERIOD - 1)) ? 8'd0 : r150 + 8'd1;
        r20_next  = (r20 == 5'(slpg_pkg::SEND_PERIOD - 1)) ? 5'd0 : r20 + 5'd1;
      end
    end
  end

  always_comb begin
    s1_next.valid = accept && (cmd.func == slpg_pkg::FUNC_TICK) &&
                    (mode <= slpg_pkg::MODE_RESET);
    s1_next.mode  = mode;
    s1_next.num   = '0;
    s1_next.lt5   = tick_count_next < 16'(slpg_pkg::FLASH_TICKS);
    s1_next.on    = 1'b0;
    case (mode)
      slpg_pkg::MODE_BOOT: begin
        s1_next.num = (r50_next < 6'(slpg_pkg::LONG_PERIOD / 2)) ? 7'(r50_next)
                    : 7'(6'(slpg_pkg::LONG_PERIOD) - r50_next);
      end
      slpg_pkg::MODE_CONFIG: begin
        s1_next.num = (r150_next < 8'(slpg_pkg::CONFIG_PERIOD / 2)) ? 7'(r150_next)
                    : 7'(8'(slpg_pkg::CONFIG_PERIOD) - r150_next);
      end
      slpg_pkg::MODE_SEND: begin
        s1_next.num = (r20_next < 5'(slpg_pkg::SEND_PERIOD / 2)) ? 7'(r20_next)
                    : 7'(5'(slpg_pkg::SEND_PERIOD) - r20_next);
      end
      slpg_pkg::MODE_ERROR, slpg_pkg::MODE_NOPEER: begin
        s1_next.on = r50_next < 6'(slpg_pkg::LONG_PERIOD / 2);
      end
      slpg_pkg::MODE_RESET: begin
        s1_next.on = !tick_count_next[slpg_pkg::RESET_BLINK_BIT];
      end
      default: begin
        s1_next.num = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= slpg_pkg::MODE_OFF;
      tick_count <= '0;
      r50        <= '0;
      r150       <= '0;
      r20        <= '0;
      s1.valid   <= 1'b0;
    end else begin
      mode       <= mode_next;
      tick_count <= tick_count_next;
      r50        <= r50_next;
      r150       <= r150_next;
      r20        <= r20_next;
      if (adv) begin
        s1 <= s1_next;
      end
    end
  end

  `SLPG_ASSERT_NEXT(a_mode_clear, mode_change, phase_clear, "mode change left counters set")
  `SLPG_ASSERT(a_phase_range, 1'b1, phase_ok, "phase out of range")

endmodule

// ----- hw/rtl/slpg_shade.sv -----
`include "status_led_pattern_generator_top_macros.svh"

module slpg_shade (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       peak_level,
  input  slpg_pkg::stage_t s1,
  output logic             adv,
  slpg_rgb_if.source       colour
);

  typedef struct packed {
    logic        valid;
    logic [3:0]  mode;
    logic [14:0] prod;
    logic        lt5;
    logic        on;
  } shade_stage_t;

  shade_stage_t     s2;
  logic [17:0]      recip;
  logic [32:0]      scaled;
  logic [7:0]       level;
  slpg_pkg::rgb_t   colour_next;
  slpg_pkg::rgb_t   last_colour;
  slpg_pkg::rgb_t   out_data;
  logic             out_valid;
  logic             differ;

  assign adv          = !out_valid || colour.ready;
  assign colour.valid = out_valid;
  assign colour.red   = out_data.red;
  assign colour.green = out_data.green;
  assign colour.blue  = out_data.blue;

  always_comb begin
    case (s2.mode)
      slpg_pkg::MODE_BOOT:   recip = slpg_pkg::RECIP_LONG;
      slpg_pkg::MODE_CONFIG: recip = slpg_pkg::RECIP_CONFIG;
      slpg_pkg::MODE_SEND:   recip = slpg_pkg::RECIP_SEND;
      default:               recip = '0;
    endcase
    scaled = 33'(s2.prod) * 33'(recip);
    level  = 8'(scaled >> slpg_pkg::RECIP_SHIFT);
  end

  always_comb begin
    colour_next = '0;
    case (s2.mode)
      slpg_pkg::MODE_BOOT:   colour_next = '{level, level, level};
      slpg_pkg::MODE_CONFIG: colour_next = '{8'd0, level, level};
      slpg_pkg::MODE_IDLE:   colour_next = '{8'd0, peak_level >> 2, 8'd0};
      slpg_pkg::MODE_CAPTURE: begin
        colour_next = s2.lt5 ? slpg_pkg::rgb_t'{8'd0, 8'd0, peak_level}
                             : slpg_pkg::rgb_t'{8'd0, peak_level >> 2, 8'd0};
      end
      slpg_pkg::MODE_SEND:   colour_next = '{level, 8'd0, level};
      slpg_pkg::MODE_ERROR: begin
        colour_next = s2.on ? slpg_pkg::rgb_t'{peak_level, 8'd0, 8'd0} : '0;
      end
      slpg_pkg::MODE_NOPEER: begin
        colour_next = s2.on ? slpg_pkg::rgb_t'{peak_level, peak_level >> 1, 8'd0} : '0;
      end
      slpg_pkg::MODE_RESET: begin
        colour_next = s2.on ? slpg_pkg::rgb_t'{peak_level, peak_level >> 2, 8'd0} : '0;
      end
      default:               colour_next = '0;
    endcase
    differ = colour_next != last_colour;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid    <= 1'b0;
      out_valid   <= 1'b0;
      last_colour <= '0;
    end else if (adv) begin
      s2.valid  <= s1.valid;
      s2.mode   <= s1.mode;
      s2.prod   <= 15'(s1.num) * 15'(peak_level);
      s2.lt5    <= s1.lt5;
      s2.on     <= s1.on;
      out_valid <= s2.valid && differ;
      if (s2.valid && differ) begin
        last_colour <= colour_next;
        out_data    <= colour_next;
      end
    end
  end

  `SLPG_ASSERT(a_out_matches_last, out_valid, out_data == last_colour, "stale output colour")
  `SLPG_ASSERT(a_level_bound, s2.valid, level <= peak_level, "breathe level above peak")

endmodule

// ----- hw/rtl/status_led_pattern_generator_top.sv -----
// An accepted tick passes through the phase, product and colour registers; its colour is presented when it changes.
// Throughput: one transaction per cycle; phase, product and colour stages advance together.
// The pipeline holds only while a shown colour waits on the output.
// Reset: mode off, tick counter zero, last colour black, peak level 40, no output valid.
module status_led_pattern_generator_top (
  input logic        clk,
  input logic        rst,
  slpg_cmd_if.sink   cmd,
  slpg_cfg_if.sink   cfg,
  slpg_rgb_if.source colour
);

  logic [7:0]       peak_level;
  logic             adv;
  slpg_pkg::stage_t s1;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_level <= slpg_pkg::PEAK_LEVEL_RESET;
    end else if (cfg.valid) begin
      peak_level <= cfg.data;
    end
  end

  slpg_phase u_phase (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .cmd (cmd),
    .s1  (s1)
  );

  slpg_shade u_shade (
    .clk        (clk),
    .rst        (rst),
    .peak_level (peak_level),
    .s1         (s1),
    .adv        (adv),
    .colour     (colour)
  );

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

  localparam logic [3:0] MODE_UNKNOWN_LO  = 4'd9;
  localparam logic [3:0] MODE_UNKNOWN_HI  = 4'd15;
  localparam int         BLINK_HALF       = slpg_pkg::LONG_PERIOD / 2;
  localparam int         RESET_BLINK      = 8;
  localparam int         SETTLE_CYCLES    = 8;
  localparam int         CYCLE_LIMIT      = 600000;

  logic clk;
  logic rst;

  slpg_cmd_if cmd_ch();
  slpg_cfg_if cfg_ch();
  slpg_rgb_if rgb_ch();

  status_led_pattern_generator_top u_top (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .cfg    (cfg_ch),
    .colour (rgb_ch)
  );

  logic [7:0]     led_bright;
  logic [3:0]     led_mode;
  logic [15:0]    led_ticks;
  slpg_pkg::rgb_t led_last;
  slpg_pkg::rgb_t colours_due[$];

  int errors = 0;
  int cycles = 0;
  bit tx_gaps = 1'b1;
  bit long_hold_req = 1'b0;
  int long_hold_len = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] breathe_level(logic [15:0] c, int period, logic [7:0] m);
    int phase;
    int half;
    int num;
    phase = int'(c) % period;
    half = period / 2;
    num = (phase < half) ? phase : period - phase;
    return 8'((num * int'(m)) / half);
  endfunction

  function automatic slpg_pkg::rgb_t pattern_colour(logic [3:0] md, logic [15:0] c,
                                                    logic [7:0] m, output bit known);
    slpg_pkg::rgb_t col;
    logic [7:0] v;
    col = '0;
    known = 1'b1;
    case (md)
      slpg_pkg::MODE_OFF: col = '0;
      slpg_pkg::MODE_BOOT: begin
        v = breathe_level(c, slpg_pkg::LONG_PERIOD, m);
        col.red = v;
        col.green = v;
        col.blue = v;
      end
      slpg_pkg::MODE_CONFIG: begin
        v = breathe_level(c, slpg_pkg::CONFIG_PERIOD, m);
        col.green = v;
        col.blue = v;
      end
      slpg_pkg::MODE_IDLE: col.green = m >> 2;
      slpg_pkg::MODE_CAPTURE: begin
        if (int'(c) < slpg_pkg::FLASH_TICKS) col.blue = m;
        else col.green = m >> 2;
      end
      slpg_pkg::MODE_SEND: begin
        v = breathe_level(c, slpg_pkg::SEND_PERIOD, m);
        col.red = v;
        col.blue = v;
      end
      slpg_pkg::MODE_ERROR: begin
        if ((int'(c) % slpg_pkg::LONG_PERIOD) < BLINK_HALF) col.red = m;
      end
      slpg_pkg::MODE_NOPEER: begin
        if ((int'(c) % slpg_pkg::LONG_PERIOD) < BLINK_HALF) begin
          col.red = m;
          col.green = m >> 1;
        end
      end
      slpg_pkg::MODE_RESET: begin
        if ((int'(c) % RESET_BLINK) < RESET_BLINK / 2) begin
          col.red = m;
          col.green = m >> 2;
        end
      end
      default: known = 1'b0;
    endcase
    return col;
  endfunction

  task automatic record_cmd(logic f, logic [3:0] mv);
    slpg_pkg::rgb_t col;
    bit known;
    if (f == slpg_pkg::FUNC_MODE) begin
      if (mv != led_mode) begin
        led_mode = mv;
        led_ticks = '0;
      end
    end else begin
      led_ticks = led_ticks + 16'd1;
      col = pattern_colour(led_mode, led_ticks, led_bright, known);
      if (known && col != led_last) begin
        led_last = col;
        colours_due.push_back(col);
      end
    end
  endtask

  task automatic send_cmd(logic f, logic [3:0] mv);
    int gap;
    gap = tx_gaps ? idle_len() : 0;
    if (gap > 0) begin
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid = 1'b1;
    cmd_ch.func = f;
    cmd_ch.mode_value = mv;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    record_cmd(f, mv);
    @(negedge clk);
  endtask

  task automatic wait_for_colours();
    cmd_ch.valid = 1'b0;
    while (colours_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_bright(logic [7:0] val);
    wait_for_colours();
    cfg_ch.valid = 1'b1;
    cfg_ch.data = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    led_bright = val;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic test_directed();
    send_cmd(slpg_pkg::FUNC_TICK, slpg_pkg::MODE_OFF);
    send_cmd(slpg_pkg::FUNC_MODE, slpg_pkg::MODE_BOOT);
    send_cmd(slpg_pkg::FUNC_TICK, slpg_pkg::MODE_OFF);
    send_cmd(slpg_pkg::FUNC_MODE, slpg_pkg::MODE_BOOT);
    send_cmd(slpg_pkg::FUNC_TICK, MODE_UNKNOWN_HI);
    send_cmd(slpg_pkg::FUNC_MODE, slpg_pkg::MODE_CONFIG);
    send_cmd(slpg_pkg::FUNC_TICK, slpg_pkg::MODE_OFF);
    send_cmd(slpg_pkg::FUNC_MODE, slpg_pkg::MODE_IDLE);
    send_cmd(slpg_pkg::FUNC_TICK, slpg_pkg::MODE_OFF);
    send_cmd(slpg_pkg::FUNC_MODE, slpg_pkg::MODE_CAPTURE);
    send_cmd(slpg_pkg::FUNC_TICK, slpg_pkg::MODE_OFF);
    send_cmd(slpg_pkg::FUNC_MODE, slpg_pkg::MODE_SEND);
    send_cmd(slpg_pkg::FUNC_TICK, slpg_pkg::MODE_OFF);
    send_cmd(slpg_pkg::FUNC_MODE, slpg_pkg::MODE_ERROR);
    send_cmd(slpg_pkg::FUNC_TICK, slpg_pkg::MODE_OFF);
    send_cmd(slpg_pkg::FUNC_MODE, slpg_pkg::MODE_NOPEER);
    send_cmd(slpg_pkg::FUNC_TICK, slpg_pkg::MODE_OFF);
    send_cmd(slpg_pkg::FUNC_MODE, slpg_pkg::MODE_RESET);
    send_cmd(slpg_pkg::FUNC_TICK, slpg_pkg::MODE_OFF);
    send_cmd(slpg_pkg::FUNC_MODE, MODE_UNKNOWN_HI);
    send_cmd(slpg_pkg::FUNC_TICK, slpg_pkg::MODE_OFF);
    send_cmd(slpg_pkg::FUNC_MODE, MODE_UNKNOWN_LO);
    send_cmd(slpg_pkg::FUNC_TICK, slpg_pkg::MODE_OFF);
    send_cmd(slpg_pkg::FUNC_MODE, slpg_pkg::MODE_OFF);
    send_cmd(slpg_pkg::FUNC_TICK, slpg_pkg::MODE_OFF);
  endtask

  task automatic test_backpressure();
    write_bright(8'd255);
    send_cmd(slpg_pkg::FUNC_MODE, slpg_pkg::MODE_SEND);
    tx_gaps = 1'b0;
    long_hold_len = 200;
    long_hold_req = 1'b1;
    repeat (60) send_cmd(slpg_pkg::FUNC_TICK, 4'($urandom));
    tx_gaps = 1'b1;
    wait_for_colours();
  endtask

  task automatic test_random();
    int p;
    int sent;
    int n;
    int r;
    logic [7:0] b;
    logic [3:0] md;
    for (p = 0; p < 5; p++) begin
      case (p)
        0: b = 8'd0;
        1: b = 8'd255;
        3: b = 8'd1;
        default: b = 8'($urandom_range(2, 254));
      endcase
      write_bright(b);
      sent = 0;
      while (sent < 55) begin
        if ($urandom_range(0, 99) < 85) begin
          md = 4'($urandom_range(slpg_pkg::MODE_OFF, slpg_pkg::MODE_RESET));
        end else begin
          md = 4'($urandom_range(MODE_UNKNOWN_LO, MODE_UNKNOWN_HI));
        end
        send_cmd(slpg_pkg::FUNC_MODE, md);
        sent++;
        n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 30) : $urandom_range(30, 90);
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (r < 5) send_cmd(slpg_pkg::FUNC_MODE, led_mode);
          else if (r < 8) send_cmd(slpg_pkg::FUNC_MODE, 4'($urandom));
          else send_cmd(slpg_pkg::FUNC_TICK, 4'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    int hold;
    int r;
    hold = 0;
    rgb_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = long_hold_len;
      end
      if (hold > 0) begin
        rgb_ch.ready = 1'b0;
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          rgb_ch.ready = 1'b1;
        end else begin
          rgb_ch.ready = 1'b0;
          hold = idle_len();
        end
      end
    end
  end

  always @(posedge clk) begin : check_colour
    slpg_pkg::rgb_t exp_col;
    if (!rst && rgb_ch.valid && rgb_ch.ready) begin
      if (colours_due.size() == 0) begin
        $error("unexpected colour red %0d green %0d blue %0d",
               rgb_ch.red, rgb_ch.green, rgb_ch.blue);
        errors++;
      end else begin
        exp_col = colours_due.pop_front();
        if (rgb_ch.red !== exp_col.red) begin
          $error("red: expected %0d, actual %0d", exp_col.red, rgb_ch.red);
          errors++;
        end
        if (rgb_ch.green !== exp_col.green) begin
          $error("green: expected %0d, actual %0d", exp_col.green, rgb_ch.green);
          errors++;
        end
        if (rgb_ch.blue !== exp_col.blue) begin
          $error("blue: expected %0d, actual %0d", exp_col.blue, rgb_ch.blue);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $error("timeout with %0d colours outstanding", colours_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.func = slpg_pkg::FUNC_TICK;
    cmd_ch.mode_value = slpg_pkg::MODE_OFF;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    led_bright = slpg_pkg::PEAK_LEVEL_RESET;
    led_mode = slpg_pkg::MODE_OFF;
    led_ticks = '0;
    led_last = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_backpressure();
    test_random();
    wait_for_colours();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
